@@ src/ptbl_pkg.sv @@
// shared types and constants for the per-client token bucket limiter
package ptbl_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_RATE     = 2'd1;
    localparam logic [1:0] CFG_TTL      = 2'd2;

    localparam logic [15:0] CAPACITY_RESET = 16'd10;
    localparam logic [31:0] RATE_RESET     = 32'd65536;
    localparam logic [31:0] TTL_RESET      = 32'd10000;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_DECIDE,
        ST_DIV,
        ST_OUT,
        ST_CLEAR
    } exec_state_t;

endpackage

@@ src/ptbl_ram.sv @@
// generic ram with one write port and one registered read port
module ptbl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/ptbl_front.sv @@
// request intake: two-entry queue holding client index and timestamp
module ptbl_front #(
    parameter int IDX_W = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [9:0]       client_id,
    input  logic [31:0]      timestamp,
    output logic             req_valid,
    input  logic             req_take,
    output logic [IDX_W-1:0] req_idx,
    output logic [31:0]      req_time
);

    logic [IDX_W-1:0] idx_reg [2];
    logic [31:0]      time_reg [2];
    logic             wptr_reg, rptr_reg;
    logic [1:0]       count_reg;
    logic             do_push, do_pop;
    logic [IDX_W-1:0] idx_in;

    assign full      = count_reg[1];
    assign req_valid = count_reg != 2'd0;
    assign do_push   = push && !full;
    assign do_pop    = req_take && req_valid;
    assign req_idx   = idx_reg[rptr_reg];
    assign req_time  = time_reg[rptr_reg];

    // index modulo the entry count (power of two)
    always_comb
    begin
        logic [26:0] wide;
        wide   = {17'd0, client_id};
        idx_in = wide[IDX_W-1:0];
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            idx_reg[wptr_reg]  <= idx_in;
            time_reg[wptr_reg] <= timestamp;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push) wptr_reg <= !wptr_reg;
            if (do_pop)  rptr_reg <= !rptr_reg;
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |=> count_reg == 2'd2 || $past(do_pop)) else $error("full queue grew");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |-> count_reg != 2'd0) else $error("pop from empty queue");

endmodule

@@ src/ptbl_exec.sv @@
// bucket update engine: table read-modify-write, refill, charge, retry divider
module ptbl_exec #(
    parameter int IDX_W  = 10,
    parameter int CLIENTS = 1024,
    parameter int FRAC_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_take,
    input  logic [IDX_W-1:0] req_idx,
    input  logic [31:0]      req_time,
    input  logic [15:0]      capacity,
    input  logic [31:0]      rate,
    input  logic [31:0]      ttl,
    output logic             empty,
    input  logic             pop,
    output logic             allowed,
    output logic [15:0]      tokens_left,
    output logic [31:0]      retry_after
);

    localparam logic [32:0] ONE = 33'd1 << FRAC_W;
    localparam logic [32:0] MAX32 = 33'h0_FFFF_FFFF;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CLIENTS - 1);

    ptbl_pkg::exec_state_t state_reg, state_next;

    logic [IDX_W-1:0]   clr_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [31:0]        time_reg;
    logic [63:0]        prod_reg;
    logic [32:0]        need_reg;
    logic [31:0]        quot_reg;
    logic [32:0]        rem_reg;
    logic [5:0]         cnt_reg;
    logic               out_allowed_reg;
    logic [15:0]        out_tokens_reg;
    logic [31:0]        out_retry_reg;

    logic [31:0]      lvl_rd;
    logic [32:0]      seen_rd;
    logic             ent_valid;
    logic             clearing;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [31:0]      lvl_wdata;
    logic [32:0]      seen_wdata;
    logic [31:0]      elapsed;
    logic [32:0]      cap_fixed;
    logic [64:0]      refill_sum;
    logic [32:0]      refill_lvl;
    logic [33:0]      rem_shift;
    logic             div_bit;
    logic [31:0]      quot_next;
    logic [32:0]      fresh_lvl;

    // level table, and last-seen time table with a valid bit
    ptbl_ram #(.WIDTH(32), .DEPTH(CLIENTS)) u_level (
        .clk(clk), .we(we), .waddr(waddr), .wdata(lvl_wdata),
        .raddr(idx_reg), .rdata(lvl_rd)
    );
    ptbl_ram #(.WIDTH(33), .DEPTH(CLIENTS)) u_seen (
        .clk(clk), .we(we), .waddr(waddr), .wdata(seen_wdata),
        .raddr(idx_reg), .rdata(seen_rd)
    );

    // capacity in fixed point, saturated to 32 bits
    always_comb
    begin
        logic [47:0] c;
        c = {32'd0, capacity} << FRAC_W;
        cap_fixed = (c > 48'h0000_FFFF_FFFF) ? MAX32 : c[32:0];
    end

    // table write source: clearing pass or request update
    assign clearing   = state_reg == ptbl_pkg::ST_CLEAR;
    assign waddr      = clearing ? clr_reg : idx_reg;
    assign seen_wdata = clearing ? 33'd0 : {1'b1, time_reg};
    assign ent_valid  = seen_rd[32];

    assign fresh_lvl  = (cap_fixed >= ONE) ? cap_fixed - ONE : 33'd0;
    assign elapsed    = time_reg - seen_rd[31:0];
    assign refill_sum = {33'd0, lvl_rd} + {1'b0, prod_reg};
    assign refill_lvl = (refill_sum > {32'd0, cap_fixed}) ? cap_fixed : refill_sum[32:0];
    assign rem_shift  = {rem_reg, need_reg[32]};
    assign div_bit    = rem_shift >= {2'd0, rate};
    assign quot_next  = {quot_reg[30:0], div_bit};

    assign empty       = state_reg != ptbl_pkg::ST_OUT;
    assign allowed     = out_allowed_reg;
    assign tokens_left = out_tokens_reg;
    assign retry_after = out_retry_reg;

    // sequencer next state and table write
    always_comb
    begin
        state_next = state_reg;
        req_take   = 1'b0;
        we         = 1'b0;
        lvl_wdata  = 32'd0;
        unique case (state_reg)
            ptbl_pkg::ST_CLEAR:
            begin
                we = 1'b1;
                if (clr_reg == LAST_IDX) state_next = ptbl_pkg::ST_IDLE;
            end
            ptbl_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_take   = 1'b1;
                    state_next = ptbl_pkg::ST_READ;
                end
            end
            ptbl_pkg::ST_READ:   state_next = ptbl_pkg::ST_MUL;
            ptbl_pkg::ST_MUL:    state_next = ptbl_pkg::ST_DECIDE;
            ptbl_pkg::ST_DECIDE:
            begin
                we = 1'b1;
                if (!ent_valid || elapsed >= ttl)
                begin
                    lvl_wdata  = fresh_lvl[31:0];
                    state_next = ptbl_pkg::ST_OUT;
                end
                else if (refill_lvl < ONE)
                begin
                    lvl_wdata  = refill_lvl[31:0];
                    state_next = (rate == 32'd0) ? ptbl_pkg::ST_OUT : ptbl_pkg::ST_DIV;
                end
                else
                begin
                    lvl_wdata  = refill_lvl[31:0] - ONE[31:0];
                    state_next = ptbl_pkg::ST_OUT;
                end
            end
            ptbl_pkg::ST_DIV:
            begin
                if (cnt_reg == 6'd0) state_next = ptbl_pkg::ST_OUT;
            end
            ptbl_pkg::ST_OUT:
            begin
                if (pop) state_next = ptbl_pkg::ST_IDLE;
            end
            default: state_next = ptbl_pkg::ST_IDLE;
        endcase
    end

    // state and clearing address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptbl_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing) clr_reg <= clr_reg + IDX_W'(1);
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ptbl_pkg::ST_IDLE:
            begin
                idx_reg  <= req_idx;
                time_reg <= req_time;
            end
            ptbl_pkg::ST_READ:
            begin
                // wait for the table read
            end
            ptbl_pkg::ST_MUL:
            begin
                prod_reg <= {32'd0, elapsed} * {32'd0, rate};
            end
            ptbl_pkg::ST_DECIDE:
            begin
                out_retry_reg <= 32'd0;
                if (!ent_valid || elapsed >= ttl)
                begin
                    out_allowed_reg <= 1'b1;
                    out_tokens_reg  <= 16'(fresh_lvl >> FRAC_W);
                end
                else if (refill_lvl < ONE)
                begin
                    out_allowed_reg <= 1'b0;
                    out_tokens_reg  <= 16'd0;
                    out_retry_reg   <= 32'hFFFF_FFFF;
                    // ceil(need / rate) as floor((need + rate - 1) / rate)
                    need_reg <= ONE - refill_lvl + {1'b0, rate} - 33'd1;
                    rem_reg  <= 33'd0;
                    quot_reg <= 32'd0;
                    cnt_reg  <= 6'd32;
                end
                else
                begin
                    out_allowed_reg <= 1'b1;
                    out_tokens_reg  <= 16'((refill_lvl - ONE) >> FRAC_W);
                end
            end
            ptbl_pkg::ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                need_reg <= {need_reg[31:0], 1'b0};
                cnt_reg  <= cnt_reg - 6'd1;
                if (div_bit)
                begin
                    rem_reg <= 33'(rem_shift - {2'd0, rate});
                end
                else
                begin
                    rem_reg <= rem_shift[32:0];
                end
                quot_reg <= quot_next;
                if (cnt_reg == 6'd0) out_retry_reg <= quot_next;
            end
            ptbl_pkg::ST_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> state_reg == ptbl_pkg::ST_DECIDE || state_reg == ptbl_pkg::ST_CLEAR)
        else $error("table write outside decide or clear");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> state_reg == ptbl_pkg::ST_READ) else $error("take without read");
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !req_take && empty) else $error("request served during clear");

endmodule

@@ src/per_client_token_bucket_limiter.sv @@
// top level of the per-client token bucket limiter
//
// Requests enter through a queue-style port: client_id and timestamp are
// taken on a clock edge with push high and full low. A two-entry front
// queue holds requests while the back end works on one at a time.
// Each request yields one result on allowed, tokens_left, retry_after,
// shown while empty is low and taken when pop is high.
// A grant passes through the read, multiply and decide states before its
// result shows; a denial with a nonzero rate adds a radix-2 divider pass
// for the retry time. The back end takes a new request only after the
// last result has been popped. The bucket table lives in two rams with a
// valid bit beside each entry's time. After reset a clearing pass over all
// CLIENTS entries (1024 by default) marks every entry unused; meanwhile up
// to two requests wait in the front. Configuration is written through
// cfg_we, cfg_index, cfg_data; the user must write it only while idle,
// which the block does not enforce. When the receiver holds off pop, the
// result stays and the front queue fills, then full rises.
module per_client_token_bucket_limiter #(
    parameter int CLIENTS       = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [9:0]  client_id,
    input  logic [31:0] timestamp,
    output logic        empty,
    input  logic        pop,
    output logic        allowed,
    output logic [15:0] tokens_left,
    output logic [31:0] retry_after,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int IDX_W = $clog2(CLIENTS);

    logic [15:0] cap_reg;
    logic [31:0] rate_reg, ttl_reg;
    logic             req_valid, req_take;
    logic [IDX_W-1:0] req_idx;
    logic [31:0]      req_time;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= ptbl_pkg::CAPACITY_RESET;
            rate_reg <= ptbl_pkg::RATE_RESET;
            ttl_reg  <= ptbl_pkg::TTL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ptbl_pkg::CFG_CAPACITY: cap_reg  <= cfg_data[15:0];
                ptbl_pkg::CFG_RATE:     rate_reg <= cfg_data;
                ptbl_pkg::CFG_TTL:      ttl_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    ptbl_front #(.IDX_W(IDX_W)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .client_id(client_id), .timestamp(timestamp),
        .req_valid(req_valid), .req_take(req_take),
        .req_idx(req_idx), .req_time(req_time)
    );

    ptbl_exec #(.IDX_W(IDX_W), .CLIENTS(CLIENTS), .FRAC_W(FRACTION_BITS)) u_exec (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_take(req_take),
        .req_idx(req_idx), .req_time(req_time),
        .capacity(cap_reg), .rate(rate_reg), .ttl(ttl_reg),
        .empty(empty), .pop(pop),
        .allowed(allowed), .tokens_left(tokens_left), .retry_after(retry_after)
    );

endmodule
